>>> rtl/core/block_match_best_candidate_search_assert.svh
// Assertion macros shared by the block match candidate search RTL.
`ifndef BLOCK_MATCH_BEST_CANDIDATE_SEARCH_ASSERT_SVH
`define BLOCK_MATCH_BEST_CANDIDATE_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define BMBCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmbcs: same-cycle implication failed");
// Next-cycle implication, checked on every clock edge outside reset.
`define BMBCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmbcs: next-cycle implication failed");
`else
`define BMBCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BMBCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/bmbcs_pkg.sv
// Shared types, constants and helpers for the block match candidate search.
package bmbcs_pkg;

    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int ACT_W      = 2;
    localparam int SIDE_W     = 5;
    localparam int OUT_IDX_W  = 16;
    localparam int DIST_W     = 40;
    localparam int Q_W        = 10;
    localparam int E_W        = 13;
    localparam int M_W        = 11;
    localparam int SQ_W       = 2 * M_W;
    localparam int TRI_W      = SQ_W + 2;

    localparam int DEF_MAX_SIDE   = 16;
    localparam int DEF_INDEX_BITS = 16;

    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(8);

    localparam logic [ACT_W-1:0] ACT_REF    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CAND   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REPORT = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_ref;
        logic wr_cand;
        logic report;
        logic pass_start;
        logic sum_mode;
        logic err_mode;
        logic div_start;
        logic load_q;
        logic compare;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic wrap;
        logic pass_busy;
        logic div_busy;
    } t_stat;

    // Channel 0 is red in the top byte, channel 2 is blue in the bottom byte.
    function automatic logic [CH_W-1:0] chan(input logic [PIX_W-1:0] px,
                                             input int unsigned     c);
        return px[(NUM_CH - 1 - c) * CH_W +: CH_W];
    endfunction

endpackage

>>> rtl/core/bmbcs_div.sv
// Restoring shift-subtract divider lane giving a quotient truncated toward zero.
module bmbcs_div #(
    parameter int SUM_W = 16,
    parameter int CNT_W = 9
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [SUM_W:0]               i_diff,
    input  logic [CNT_W-1:0]                    i_divisor,
    output logic                                o_busy,
    output logic signed [bmbcs_pkg::Q_W-1:0]    o_quot
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]                    r_dvd;
    logic [CNT_W-1:0]                    r_rem;
    logic [STEP_W-1:0]                   r_step;
    logic                                r_busy;
    logic                                r_neg;
    logic [SUM_W:0]                      w_abs;
    logic [CNT_W:0]                      w_trial;
    logic                                w_ge;
    logic signed [bmbcs_pkg::Q_W-1:0]    w_mag;

    always_comb begin
        w_abs   = i_diff[SUM_W] ? (SUM_W + 1)'(-i_diff) : (SUM_W + 1)'(i_diff);
        w_trial = {r_rem, r_dvd[SUM_W-1]};
        w_ge    = (w_trial >= {1'b0, i_divisor});
        // The magnitude never exceeds one channel's full scale.
        w_mag   = signed'(r_dvd[bmbcs_pkg::Q_W-1:0]);
        o_quot  = r_neg ? -w_mag : w_mag;
        o_busy  = r_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(SUM_W);
        end else if (r_busy) begin
            r_step <= r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= w_abs[SUM_W-1:0];
            r_rem <= '0;
            r_neg <= i_diff[SUM_W];
        end else if (r_busy) begin
            r_dvd <= {r_dvd[SUM_W-2:0], w_ge};
            r_rem <= w_ge ? CNT_W'(w_trial - {1'b0, i_divisor}) : w_trial[CNT_W-1:0];
        end
    end

endmodule

>>> rtl/core/bmbcs_dpath.sv
// Datapath: pixel stores, channel sums, offset dividers, error pipeline, best tracking.
module bmbcs_dpath #(
    parameter int MAX_SIDE   = bmbcs_pkg::DEF_MAX_SIDE,
    parameter int INDEX_BITS = bmbcs_pkg::DEF_INDEX_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bmbcs_pkg::t_cmd                        i_cmd,
    output bmbcs_pkg::t_stat                       o_stat,
    input  logic                                   i_cfg_we,
    input  logic [bmbcs_pkg::SIDE_W-1:0]           i_cfg_data,
    input  logic [bmbcs_pkg::PIX_W-1:0]            i_pixel,
    output logic [bmbcs_pkg::OUT_IDX_W-1:0]        o_best_index,
    output logic [bmbcs_pkg::DIST_W-1:0]           o_best_distance,
    output logic                                   o_none_seen
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = $clog2(DEPTH * ((1 << bmbcs_pkg::CH_W) - 1) + 1);
    localparam int SW     = bmbcs_pkg::SIDE_W;
    localparam int NCH    = bmbcs_pkg::NUM_CH;
    localparam logic [SW:0] SIDE_MAX = (SW + 1)'(MAX_SIDE);

    // Configuration and position.
    logic [SW-1:0]        r_side;
    logic [SW:0]          w_side;
    logic [2*SW+1:0]      w_side_sq;
    logic [CNT_W-1:0]     w_n;
    logic [ADDR_W-1:0]    r_pos;
    logic [ADDR_W-1:0]    w_wa;
    logic [CNT_W-1:0]     w_next;
    logic                 w_wrap;

    // Pixel stores and read pipeline.
    logic [bmbcs_pkg::PIX_W-1:0] r_ref_mem  [DEPTH];
    logic [bmbcs_pkg::PIX_W-1:0] r_cand_mem [DEPTH];
    logic [bmbcs_pkg::PIX_W-1:0] r_ref_q;
    logic [bmbcs_pkg::PIX_W-1:0] r_cand_q;
    logic [ADDR_W-1:0]    r_idx;
    logic                 r_issue;
    logic                 r_rd_v;
    logic                 r_sq_v;
    logic                 w_idx_last;

    // Per-channel arithmetic.
    logic [SUM_W-1:0]                   r_rsum [NCH];
    logic [SUM_W-1:0]                   r_csum [NCH];
    logic signed [SUM_W:0]              w_diff [NCH];
    logic                               w_div_busy [NCH];
    logic signed [bmbcs_pkg::Q_W-1:0]   w_quot [NCH];
    logic signed [bmbcs_pkg::Q_W-1:0]   r_q    [NCH];
    logic [bmbcs_pkg::E_W-1:0]          w_e    [NCH];
    logic [bmbcs_pkg::E_W-1:0]          w_eabs [NCH];
    logic [bmbcs_pkg::M_W-1:0]          w_mag  [NCH];
    logic [bmbcs_pkg::SQ_W-1:0]         w_sq   [NCH];
    logic [bmbcs_pkg::SQ_W-1:0]         r_sq   [NCH];

    // Distance accumulation and best tracking.
    logic [bmbcs_pkg::TRI_W-1:0]        w_tri;
    logic [bmbcs_pkg::DIST_W:0]         w_acc;
    logic [bmbcs_pkg::DIST_W-1:0]       r_dist;
    logic [bmbcs_pkg::DIST_W-1:0]       r_best_d;
    logic [INDEX_BITS-1:0]              r_best_i;
    logic [INDEX_BITS-1:0]              r_count;
    logic                               r_have;
    logic                               w_better;
    logic [bmbcs_pkg::OUT_IDX_W-1:0]    r_o_idx;
    logic [bmbcs_pkg::DIST_W-1:0]       r_o_dist;
    logic                               r_o_none;

    always_comb begin
        // A side of zero acts as one; a side above the maximum is clamped.
        w_side = {1'b0, r_side};
        if (w_side == '0) begin
            w_side = (SW + 1)'(1);
        end else if (w_side > SIDE_MAX) begin
            w_side = SIDE_MAX;
        end
        w_side_sq = {{(SW + 1){1'b0}}, w_side} * {{(SW + 1){1'b0}}, w_side};
        w_n       = w_side_sq[CNT_W-1:0];

        // A stale position beyond a shrunken block restarts at zero.
        w_wa   = (CNT_W'(r_pos) >= w_n) ? '0 : r_pos;
        w_next = CNT_W'(w_wa) + CNT_W'(1);
        w_wrap = (w_next >= w_n);

        w_idx_last = ((CNT_W'(r_idx) + CNT_W'(1)) == w_n);

        for (int c = 0; c < NCH; c++) begin
            w_diff[c] = signed'({1'b0, r_rsum[c]}) - signed'({1'b0, r_csum[c]});
            // Scaled error term: 3*cand + 4*q - 4*ref, in modular two's complement.
            w_e[c] = (bmbcs_pkg::E_W'(bmbcs_pkg::chan(r_cand_q, c)) << 1)
                   + bmbcs_pkg::E_W'(bmbcs_pkg::chan(r_cand_q, c))
                   + (bmbcs_pkg::E_W'(r_q[c]) << 2)
                   - (bmbcs_pkg::E_W'(bmbcs_pkg::chan(r_ref_q, c)) << 2);
            w_eabs[c] = w_e[c][bmbcs_pkg::E_W-1] ? -w_e[c] : w_e[c];
            w_mag[c]  = w_eabs[c][bmbcs_pkg::M_W-1:0];
            w_sq[c]   = w_mag[c] * w_mag[c];
        end

        w_tri = bmbcs_pkg::TRI_W'(r_sq[0]) + bmbcs_pkg::TRI_W'(r_sq[1])
              + bmbcs_pkg::TRI_W'(r_sq[2]);
        w_acc = {1'b0, r_dist} + (bmbcs_pkg::DIST_W + 1)'(w_tri);

        w_better = !r_have || (r_dist < r_best_d);

        o_stat.wrap      = w_wrap;
        o_stat.pass_busy = r_issue | r_rd_v | r_sq_v;
        o_stat.div_busy  = w_div_busy[0] | w_div_busy[1] | w_div_busy[2];

        o_best_index    = r_o_idx;
        o_best_distance = r_o_dist;
        o_none_seen     = r_o_none;
    end

    for (genvar g = 0; g < NCH; g++) begin : g_div
        bmbcs_div #(
            .SUM_W (SUM_W),
            .CNT_W (CNT_W)
        ) u_div (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_start   (i_cmd.div_start),
            .i_diff    (w_diff[g]),
            .i_divisor (w_n),
            .o_busy    (w_div_busy[g]),
            .o_quot    (w_quot[g])
        );
    end

    // Pixel stores: one write port, one registered read port each.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_ref) begin
            r_ref_mem[w_wa] <= i_pixel;
        end
        if (i_cmd.wr_cand) begin
            r_cand_mem[w_wa] <= i_pixel;
        end
        r_ref_q  <= r_ref_mem[r_idx];
        r_cand_q <= r_cand_mem[r_idx];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side   <= bmbcs_pkg::SIDE_RESET;
            r_pos    <= '0;
            r_issue  <= 1'b0;
            r_rd_v   <= 1'b0;
            r_sq_v   <= 1'b0;
            r_count  <= '0;
            r_have   <= 1'b0;
            r_best_i <= '0;
            r_best_d <= '0;
        end else begin
            if (i_cfg_we) begin
                r_side <= i_cfg_data;
            end
            if (i_cmd.wr_ref || i_cmd.wr_cand) begin
                r_pos <= w_wrap ? '0 : w_next[ADDR_W-1:0];
            end
            if (i_cmd.pass_start) begin
                r_issue <= 1'b1;
            end else if (r_issue && w_idx_last) begin
                r_issue <= 1'b0;
            end
            r_rd_v <= r_issue;
            r_sq_v <= r_rd_v && i_cmd.err_mode;
            if (i_cmd.compare) begin
                if (w_better) begin
                    r_have   <= 1'b1;
                    r_best_d <= r_dist;
                    r_best_i <= r_count;
                end
                r_count <= r_count + INDEX_BITS'(1);
            end
            if (i_cmd.report) begin
                r_pos    <= '0;
                r_count  <= '0;
                r_have   <= 1'b0;
                r_best_i <= '0;
                r_best_d <= '0;
            end
        end
    end

    // Arithmetic payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.pass_start) begin
            r_idx  <= '0;
            r_dist <= '0;
        end else begin
            if (r_issue && !w_idx_last) begin
                r_idx <= r_idx + ADDR_W'(1);
            end
            if (r_sq_v) begin
                r_dist <= w_acc[bmbcs_pkg::DIST_W] ? '1 : w_acc[bmbcs_pkg::DIST_W-1:0];
            end
        end
        for (int c = 0; c < NCH; c++) begin
            if (i_cmd.pass_start) begin
                r_rsum[c] <= '0;
                r_csum[c] <= '0;
            end else if (i_cmd.sum_mode && r_rd_v) begin
                r_rsum[c] <= r_rsum[c] + SUM_W'(bmbcs_pkg::chan(r_ref_q, c));
                r_csum[c] <= r_csum[c] + SUM_W'(bmbcs_pkg::chan(r_cand_q, c));
            end
            if (i_cmd.load_q) begin
                r_q[c] <= w_quot[c];
            end
            if (i_cmd.err_mode && r_rd_v) begin
                r_sq[c] <= w_sq[c];
            end
        end
        if (i_cmd.report) begin
            r_o_idx  <= r_have ? bmbcs_pkg::OUT_IDX_W'(r_best_i) : '0;
            r_o_dist <= r_have ? r_best_d : '0;
            r_o_none <= !r_have;
        end
    end

endmodule

>>> rtl/core/bmbcs_ctrl.sv
// Controller: transaction handshakes and the evaluation sequence state machine.
module bmbcs_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [bmbcs_pkg::ACT_W-1:0]     i_action,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  bmbcs_pkg::t_stat                i_stat,
    output bmbcs_pkg::t_cmd                 o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_DIV  = 4'b0100,
        S_ERR  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_acc;

    always_comb begin
        // A report transaction needs the result register free or draining.
        o_in_ready = (r_state == S_IDLE)
                  && ((i_action != bmbcs_pkg::ACT_REPORT) || !r_out_valid || i_out_ready);
        w_acc       = i_in_valid && o_in_ready;
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.sum_mode = (r_state == S_SUM);
        o_cmd.err_mode = (r_state == S_ERR);
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_action)
                        bmbcs_pkg::ACT_REF: begin
                            o_cmd.wr_ref = 1'b1;
                        end
                        bmbcs_pkg::ACT_CAND: begin
                            o_cmd.wr_cand = 1'b1;
                            if (i_stat.wrap) begin
                                o_cmd.pass_start = 1'b1;
                                n_state          = S_SUM;
                            end
                        end
                        bmbcs_pkg::ACT_REPORT: begin
                            o_cmd.report = 1'b1;
                            n_out_valid  = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SUM: begin
                if (!i_stat.pass_busy) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    o_cmd.pass_start = 1'b1;
                    o_cmd.load_q     = 1'b1;
                    n_state          = S_ERR;
                end
            end
            S_ERR: begin
                if (!i_stat.pass_busy) begin
                    o_cmd.compare = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> rtl/core/block_match_best_candidate_search.sv
// A candidate pixel that completes a block of n pixels starts an evaluation: two walks over
// the single read port of each pixel store, with the bit-serial offset dividers (one per
// channel) run between them.
// A report result is registered and valid the cycle after its transaction is accepted.
// Reset is synchronous, active low: it clears control state and sets the side to 8;
// the pixel stores are not cleared and need no clearing pass.
`include "block_match_best_candidate_search_assert.svh"
module block_match_best_candidate_search #(
    parameter int MAX_SIDE   = bmbcs_pkg::DEF_MAX_SIDE,
    parameter int INDEX_BITS = bmbcs_pkg::DEF_INDEX_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [bmbcs_pkg::ACT_W-1:0]         i_action,
    input  logic [bmbcs_pkg::PIX_W-1:0]         i_pixel,
    input  logic                                i_cfg_we,
    input  logic [bmbcs_pkg::SIDE_W-1:0]        i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [bmbcs_pkg::OUT_IDX_W-1:0]     o_best_index,
    output logic [bmbcs_pkg::DIST_W-1:0]        o_best_distance,
    output logic                                o_none_seen
);

    bmbcs_pkg::t_cmd  w_cmd;
    bmbcs_pkg::t_stat w_stat;

    bmbcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    bmbcs_dpath #(
        .MAX_SIDE   (MAX_SIDE),
        .INDEX_BITS (INDEX_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_pixel         (i_pixel),
        .o_best_index    (o_best_index),
        .o_best_distance (o_best_distance),
        .o_none_seen     (o_none_seen)
    );

    // A report never overwrites a result that is still waiting to be taken.
`BMBCS_ASSERT_IMP(a_report_slot_free, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_action == bmbcs_pkg::ACT_REPORT), !o_out_valid || i_out_ready)
    // Completing a candidate stops input while the stores are being walked.
`BMBCS_ASSERT_NXT(a_eval_blocks_input, i_clk, i_rst_n, w_cmd.wr_cand && w_stat.wrap, !o_in_ready)
    // The dividers and the store walk never run at the same time.
`BMBCS_ASSERT_IMP(a_div_pass_exclusive, i_clk, i_rst_n, w_stat.div_busy, !w_stat.pass_busy)

endmodule
